### rtl/core/ssort_pkg.sv
// ----------------------------------------------------------------------------
// ssort_pkg: shared types and constants of the Shell sort engine
// Command and status bundles between the controller and the datapath, and
// the fixed data width and reciprocal constants for the divide by three.
// ----------------------------------------------------------------------------
package ssort_pkg;

	localparam int DATA_W = 32;

	// Divide by three as a multiply by 171 and a shift by 9. This is exact for
	// every gap value that the Knuth sequence reaches with up to 64 entries.
	localparam int DIV3_MUL   = 171;
	localparam int DIV3_SHIFT = 9;

	typedef struct packed {
		logic knuth;        // gap sequence in force
		logic load_wr;      // accepted input beat
		logic cnt_clr;      // set fully emitted
		logic h_init;
		logic h_grow;
		logic gap_first;
		logic gap_next;
		logic start_clr;
		logic start_inc;
		logic pos_init;
		logic pos_adv;
		logic rd_pos;
		logic slot_init;
		logic held_ld;
		logic rd_slot_gap;
		logic wr_shift;
		logic wr_held;
		logic k_clr;
		logic k_inc;
		logic rd_k;
		logic out_ld;
	} ssort_cmd_t;

	typedef struct packed {
		logic gap_zero;
		logic start_eq_gap;
		logic pos_ge_n;
		logic slot_ge_gap;
		logic greater;
		logic h_lt_n;
		logic k_last;
	} ssort_status_t;

endpackage

### rtl/core/ssort_ram.sv
// ----------------------------------------------------------------------------
// ssort_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module ssort_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### rtl/core/ssort_dp.sv
// ----------------------------------------------------------------------------
// ssort_dp: datapath of the Shell sort engine
// Holds the value store, the index registers of the gapped insertion passes,
// the held value, the comparator and the output register.
// ----------------------------------------------------------------------------
module ssort_dp #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ssort_pkg::ssort_cmd_t                cmd,
	output ssort_pkg::ssort_status_t             status,
	input  logic signed [ssort_pkg::DATA_W-1:0]  sample_value,
	output logic signed [ssort_pkg::DATA_W-1:0]  sorted_value,
	output logic                                 last_out
);

	import ssort_pkg::*;

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	// Gap and position values stay below three times the set size plus one.
	localparam int GW = CW + 2;
	localparam int PW = GW + 8;

	function automatic logic [GW-1:0] div3(input logic [GW-1:0] v);
		logic [PW-1:0] p;
		begin
			p = PW'(v) * PW'(DIV3_MUL);
			return GW'(p >> DIV3_SHIFT);
		end
	endfunction

	logic [CW-1:0]     count_q;
	logic [GW-1:0]     h_q;
	logic [GW-1:0]     gap_q;
	logic [GW-1:0]     start_q;
	logic [GW-1:0]     pos_q;
	logic [GW-1:0]     slot_q;
	logic [AW-1:0]     k_q;
	logic [DATA_W-1:0] held_q;
	logic [DATA_W-1:0] out_value_q;
	logic              out_last_q;

	logic              full;
	logic [GW-1:0]     n_ext;
	logic [GW-1:0]     slot_gap;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;

	assign full     = (count_q == CW'(MAX_ITEMS));
	assign n_ext    = GW'(count_q);
	assign slot_gap = slot_q - gap_q;

	always_comb begin
		wr_en   = (cmd.load_wr && !full) || cmd.wr_shift || cmd.wr_held;
		wr_addr = cmd.load_wr ? count_q[AW-1:0] : slot_q[AW-1:0];
		if (cmd.load_wr) begin
			wr_data = sample_value;
		end else if (cmd.wr_shift) begin
			wr_data = rd_data;
		end else begin
			wr_data = held_q;
		end
		if (cmd.rd_pos) begin
			rd_addr = pos_q[AW-1:0];
		end else if (cmd.rd_slot_gap) begin
			rd_addr = slot_gap[AW-1:0];
		end else if (cmd.rd_k) begin
			rd_addr = k_q;
		end else begin
			rd_addr = '0;
		end
	end

	ssort_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		status.gap_zero     = (gap_q == '0);
		status.start_eq_gap = (start_q == gap_q);
		status.pos_ge_n     = (pos_q >= n_ext);
		status.slot_ge_gap  = (slot_q >= gap_q);
		status.greater      = ($signed(rd_data) > $signed(held_q));
		status.h_lt_n       = (h_q < n_ext);
		status.k_last       = ((CW'(k_q) + CW'(1)) == count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_clr) begin
			count_q <= '0;
		end else if (cmd.load_wr && !full) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.h_init) begin
			h_q <= GW'(1);
		end else if (cmd.h_grow) begin
			h_q <= (h_q << 1) + h_q + GW'(1);
		end

		if (cmd.gap_first) begin
			gap_q <= cmd.knuth ? div3(h_q) : GW'(count_q >> 1);
		end else if (cmd.gap_next) begin
			gap_q <= cmd.knuth ? div3(gap_q) : (gap_q >> 1);
		end

		if (cmd.start_clr) begin
			start_q <= '0;
		end else if (cmd.start_inc) begin
			start_q <= start_q + GW'(1);
		end

		if (cmd.pos_init) begin
			pos_q <= start_q + gap_q;
		end else if (cmd.pos_adv) begin
			pos_q <= pos_q + gap_q;
		end

		if (cmd.slot_init) begin
			slot_q <= pos_q;
		end else if (cmd.wr_shift) begin
			slot_q <= slot_gap;
		end

		if (cmd.held_ld) begin
			held_q <= rd_data;
		end

		if (cmd.k_clr) begin
			k_q <= '0;
		end else if (cmd.k_inc) begin
			k_q <= k_q + AW'(1);
		end

		if (cmd.out_ld) begin
			out_value_q <= rd_data;
			out_last_q  <= status.k_last;
		end
	end

	assign sorted_value = out_value_q;
	assign last_out     = out_last_q;

endmodule

### rtl/core/ssort_ctrl.sv
// ----------------------------------------------------------------------------
// ssort_ctrl: controller of the Shell sort engine
// Sequences loading, gap selection, the gapped insertion passes and the
// output of the sorted set; holds the gap sequence register.
// ----------------------------------------------------------------------------
module ssort_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     is_last,
	output logic                     out_valid,
	input  logic                     out_stall,
	input  logic                     cfg_we,
	input  logic                     cfg_wdata,
	output ssort_pkg::ssort_cmd_t    cmd,
	input  ssort_pkg::ssort_status_t status
);

	import ssort_pkg::*;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SETUP,
		ST_GROW,
		ST_GAP_CHECK,
		ST_START_CHECK,
		ST_POS_CHECK,
		ST_HOLD_WAIT,
		ST_SLOT_CHECK,
		ST_CMP,
		ST_OUT_RD,
		ST_OUT_WAIT,
		ST_OUT_HOLD
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   gap_seq_q;
	logic   out_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.knuth = gap_seq_q;
		state_d   = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid) begin
					cmd.load_wr = 1'b1;
					if (is_last) begin
						state_d = ST_SETUP;
					end
				end
			end
			ST_SETUP: begin
				if (gap_seq_q) begin
					cmd.h_init = 1'b1;
					state_d    = ST_GROW;
				end else begin
					cmd.gap_first = 1'b1;
					state_d       = ST_GAP_CHECK;
				end
			end
			ST_GROW: begin
				if (status.h_lt_n) begin
					cmd.h_grow = 1'b1;
				end else begin
					cmd.gap_first = 1'b1;
					state_d       = ST_GAP_CHECK;
				end
			end
			ST_GAP_CHECK: begin
				if (status.gap_zero) begin
					cmd.k_clr = 1'b1;
					state_d   = ST_OUT_RD;
				end else begin
					cmd.start_clr = 1'b1;
					state_d       = ST_START_CHECK;
				end
			end
			ST_START_CHECK: begin
				if (status.start_eq_gap) begin
					cmd.gap_next = 1'b1;
					state_d      = ST_GAP_CHECK;
				end else begin
					cmd.pos_init = 1'b1;
					state_d      = ST_POS_CHECK;
				end
			end
			ST_POS_CHECK: begin
				if (status.pos_ge_n) begin
					cmd.start_inc = 1'b1;
					state_d       = ST_START_CHECK;
				end else begin
					cmd.rd_pos    = 1'b1;
					cmd.slot_init = 1'b1;
					state_d       = ST_HOLD_WAIT;
				end
			end
			ST_HOLD_WAIT: begin
				cmd.held_ld = 1'b1;
				state_d     = ST_SLOT_CHECK;
			end
			ST_SLOT_CHECK: begin
				if (status.slot_ge_gap) begin
					cmd.rd_slot_gap = 1'b1;
					state_d         = ST_CMP;
				end else begin
					cmd.wr_held = 1'b1;
					cmd.pos_adv = 1'b1;
					state_d     = ST_POS_CHECK;
				end
			end
			ST_CMP: begin
				// The neighbor one gap below is now on the read port.
				if (status.greater) begin
					cmd.wr_shift = 1'b1;
					state_d      = ST_SLOT_CHECK;
				end else begin
					cmd.wr_held = 1'b1;
					cmd.pos_adv = 1'b1;
					state_d     = ST_POS_CHECK;
				end
			end
			ST_OUT_RD: begin
				cmd.rd_k = 1'b1;
				state_d  = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: begin
				cmd.out_ld = 1'b1;
				state_d    = ST_OUT_HOLD;
			end
			ST_OUT_HOLD: begin
				if (!out_stall) begin
					if (status.k_last) begin
						cmd.cnt_clr = 1'b1;
						state_d     = ST_LOAD;
					end else begin
						cmd.k_inc = 1'b1;
						state_d   = ST_OUT_RD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			gap_seq_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				gap_seq_q <= cfg_wdata;
			end
			if (state_q == ST_OUT_WAIT) begin
				out_valid_q <= 1'b1;
			end else if (state_q == ST_OUT_HOLD && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_LOAD);
	assign out_valid = out_valid_q;

endmodule

### rtl/core/shell_sort_engine_core.sv
// Shell sort engine. Values are loaded one beat per cycle into an internal
// store of MAX_ITEMS entries; values beyond that are dropped. The beat marked
// is_last starts an in-place Shell sort with halving gaps or Knuth 3h+1 gaps,
// chosen by the gap sequence bit that cfg_we and cfg_wdata write, after which
// the set comes out in ascending order with last_out on the final value. The
// sort runs on one store port pair: each element of a gapped pass is read
// into the held register, each neighbour one gap below that is greater is
// shifted up one gap, and the held value is written into the slot left.
// Each sorted value is read into the output register and held there while
// out_stall is high. No input is taken from the is_last beat until the last
// sorted value has been taken.
// ----------------------------------------------------------------------------
// shell_sort_engine_core: top level of the Shell sort engine
// Joins the controller and the datapath and carries the design assertions.
// ----------------------------------------------------------------------------
module shell_sort_engine_core #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [ssort_pkg::DATA_W-1:0]  sample_value,
	input  logic                                 is_last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [ssort_pkg::DATA_W-1:0]  sorted_value,
	output logic                                 last_out,
	input  logic                                 cfg_we,
	input  logic                                 cfg_wdata
);

	import ssort_pkg::*;

	ssort_cmd_t    cmd;
	ssort_status_t status;

	ssort_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.is_last  (is_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.status   (status)
	);

	ssort_dp #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.sample_value(sample_value),
		.sorted_value(sorted_value),
		.last_out    (last_out)
	);

	// Loading and output never overlap.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("output beat shown while loading");

	// Taking the final sorted beat reopens the input in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_out) |=> !in_stall)
		else $error("input not reopened after final beat");

	// At most one source writes the store in any cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_wr, cmd.wr_shift, cmd.wr_held}))
		else $error("conflicting store writes");

	// A beat taken that is not the last one does not reopen the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_out) |=> in_stall)
		else $error("input reopened in the middle of a sorted run");

endmodule

### tb/sv/tb_shell_sort_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shell_sort_engine_core: self-checking bench for the Shell sort engine
// Streams sets of signed values into the block under both gap sequences, with
// random gaps and output back-pressure and one long output hold-off. Every
// sorted beat is checked against an in-bench Shell sort of the same set.
// ----------------------------------------------------------------------------
module tb_shell_sort_engine_core;

	localparam int STORE_DEPTH = 64;
	localparam int LONG_HOLD   = 300;
	localparam int HOLD_AFTER  = 4;

	typedef logic signed [ssort_pkg::DATA_W-1:0] word_t;

	typedef struct packed {
		word_t value;
		logic  last;
	} sorted_beat_t;

	// Holds the current set and the sorted beats still owed by the block.
	class sort_scoreboard;
		word_t        held [STORE_DEPTH];
		int unsigned  held_count;
		bit           knuth_gaps;
		sorted_beat_t owed [$];

		function new();
			held_count = 0;
			knuth_gaps = 0;
		endfunction

		function void set_gap_sequence(bit knuth);
			knuth_gaps = knuth;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function void gapped_insertion(int unsigned gap, int unsigned n);
			int unsigned start, pos, slot;
			word_t       moving;
			for (start = 0; start < gap; start++) begin
				for (pos = start + gap; pos < n; pos += gap) begin
					moving = held[pos];
					slot = pos;
					while (slot >= gap && held[slot - gap] > moving) begin
						held[slot] = held[slot - gap];
						slot -= gap;
					end
					held[slot] = moving;
				end
			end
		endfunction

		function void shell_sort(int unsigned n);
			int unsigned gap;
			if (!knuth_gaps) begin
				for (gap = n / 2; gap > 0; gap /= 2)
					gapped_insertion(gap, n);
			end else begin
				gap = 1;
				while (gap < n)
					gap = 3 * gap + 1;
				for (gap = gap / 3; gap > 0; gap /= 3)
					gapped_insertion(gap, n);
			end
		endfunction

		// Values past the store depth are dropped, even a last-marked one.
		function void note_sample(word_t value, logic last);
			sorted_beat_t beat;
			if (held_count < STORE_DEPTH) begin
				held[held_count] = value;
				held_count++;
			end
			if (last) begin
				shell_sort(held_count);
				for (int k = 0; k < held_count; k++) begin
					beat.value = held[k];
					beat.last  = (k + 1 == held_count);
					owed.push_back(beat);
				end
				held_count = 0;
			end
		endfunction

		// Returns an empty string on a match, else a description.
		function string check_sorted(word_t value, logic last);
			sorted_beat_t want;
			if (owed.size() == 0)
				return $sformatf("unexpected sorted beat value=%0d last=%0b",
					value, last);
			want = owed.pop_front();
			if (want.value !== value || want.last !== last)
				return $sformatf("sorted beat got value=%0d last=%0b, %s%0d last=%0b",
					value, last, "want value=", want.value, want.last);
			return "";
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_stall;
	word_t sample_value = '0;
	logic  is_last = 1'b0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	word_t sorted_value;
	logic  last_out;
	logic  cfg_we = 1'b0;
	logic  cfg_wdata = 1'b0;

	sort_scoreboard board;
	int             mismatches = 0;
	int             results_seen = 0;
	int             samples_sent = 0;
	int             sets_sent = 0;
	int             send_steady = 0;
	bit             long_hold_done = 0;

	shell_sort_engine_core #(
		.MAX_ITEMS(STORE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_value(sample_value),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sorted_value(sorted_value),
		.last_out(last_out),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	// Mostly short gaps, a few long ones, and now and then a steady stretch.
	function automatic int pick_gap(ref int steady);
		int r;
		if (steady > 0) begin
			steady--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			steady = 30;
			return 0;
		end
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic word_t pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2, 3: return $signed($urandom_range(0, 8)) - 4;
			default: return $urandom;
		endcase
	endfunction

	// Called just after a rising edge; returns after the beat is accepted.
	task automatic send_sample(input word_t value, input logic last);
		int gap;
		gap = pick_gap(send_steady);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		sample_value <= value;
		is_last      <= last;
		do @(posedge clk); while (in_stall);
		board.note_sample(value, last);
		samples_sent++;
		if (last) sets_sent++;
	endtask

	task automatic send_random_set(input int len);
		for (int i = 0; i < len; i++)
			send_sample(pick_value(), i == len - 1);
	endtask

	task automatic drain_and_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_gap_sequence(input bit knuth);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= knuth;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.set_gap_sequence(knuth);
		@(posedge clk);
	endtask

	// Sorted beats are checked at the edge where they are taken.
	always @(posedge clk) begin
		string msg;
		if (arst_n && out_valid && !out_stall) begin
			msg = board.check_sorted(sorted_value, last_out);
			results_seen++;
			if (msg != "") report_mismatch(msg);
		end
	end

	// Output side back-pressure, with one long hold-off while input continues.
	initial begin : receiver
		int stall_left;
		int recv_steady;
		stall_left  = 0;
		recv_steady = 0;
		forever begin
			@(negedge clk);
			if (!long_hold_done && results_seen >= HOLD_AFTER) begin
				long_hold_done = 1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_gap(recv_steady);
			end
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("TIMEOUT: sorted beats still owed = %0d", board.pending());
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int phase_items;
		int len;
		board = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets with halving gaps: single values at both extremes,
		// extremes mixed with small values, duplicates, and a reversed run.
		send_sample(32'sh7fff_ffff, 1'b1);
		send_sample(32'sh8000_0000, 1'b1);
		send_sample(32'sh7fff_ffff, 1'b0);
		send_sample(32'sh8000_0000, 1'b0);
		send_sample(0, 1'b0);
		send_sample(-1, 1'b0);
		send_sample(1, 1'b1);
		send_sample(5, 1'b0);
		send_sample(5, 1'b0);
		send_sample(-5, 1'b0);
		send_sample(5, 1'b1);
		for (int i = 0; i < 8; i++)
			send_sample(100 - 13 * i, i == 7);
		drain_and_idle();

		// Same kind of set with Knuth gaps, both bit patterns alternating.
		write_gap_sequence(1'b1);
		send_sample(32'sh8000_0000, 1'b0);
		send_sample(32'sh7fff_ffff, 1'b0);
		send_sample(32'sh8000_0000, 1'b0);
		send_sample(32'sh5555_5555, 1'b0);
		send_sample(32'shaaaa_aaaa, 1'b1);
		drain_and_idle();

		for (int phase = 0; phase < 4; phase++) begin
			write_gap_sequence(phase[0]);
			if (phase == 1) begin
				// Overfilled store: the last two beats, the marked one too, are dropped.
				send_random_set(STORE_DEPTH + 2);
			end else begin
				phase_items = 0;
				while (phase_items < 20) begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 28)
						: $urandom_range(1, 10);
					send_random_set(len);
					phase_items += len;
				end
			end
			drain_and_idle();
		end

		repeat (40) @(posedge clk);
		if (board.pending() != 0)
			report_mismatch($sformatf("%0d sorted beats never arrived", board.pending()));
		$display("Sent %0d values in %0d sets under both gap sequences, %0d beats checked.",
			samples_sent, sets_sent, results_seen);
		$display("Covered extremes, duplicates, single-value sets, an overfilled store,");
		$display("random back-pressure and a long output hold-off.");
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
